@@ rtl/transposition_table_macros.svh @@
// -----------------------------------------------------------------------------
// transposition_table_macros
// Assertion macros used by the transposition table back end (tt_back).
// -----------------------------------------------------------------------------
`ifndef TRANSPOSITION_TABLE_MACROS_SVH
`define TRANSPOSITION_TABLE_MACROS_SVH

// same-cycle implication
`define TT_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/tt_pkg.sv @@
// -----------------------------------------------------------------------------
// tt_pkg
// Types, codes and sizes for the transposition table.
// -----------------------------------------------------------------------------
package tt_pkg;

   localparam int INDEX_BITS  = 16;
   localparam int ENTRY_COUNT = 1 << INDEX_BITS;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = 1;
   localparam int QCNT_BITS   = 2;

   localparam logic [14:0] MATE_RESET = 15'd29000;

   localparam logic [1:0] CMD_PROBE = 2'd0;
   localparam logic [1:0] CMD_STORE = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   localparam logic [1:0] BOUND_ALPHA = 2'd0;
   localparam logic [1:0] BOUND_BETA  = 2'd1;
   localparam logic [1:0] BOUND_EXACT = 2'd2;

   typedef logic signed [15:0]     score_type;
   typedef logic [INDEX_BITS-1:0]  index_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_LOOK
   } back_state_type;

   // word passed from front to back
   typedef struct packed {
      logic [1:0]  command;
      logic [63:0] key;
      index_type   idx;
      logic [30:0] move_in;
      score_type   store_score;
      logic [1:0]  bound_kind;
      logic [6:0]  search_depth;
      score_type   lower_window;
      score_type   upper_window;
      logic [6:0]  ply_from_root;
   } item_type;

   typedef struct packed {
      logic        valid;
      logic [63:0] key;
      logic [30:0] move;
      score_type   score;
      logic [6:0]  depth;
      logic [1:0]  bound;
   } entry_type;

   typedef struct packed {
      logic        key_match;
      logic        cutoff;
      logic [30:0] move_out;
      score_type   score_out;
      logic [31:0] hit_count;
      logic [31:0] new_write_count;
      logic [31:0] overwrite_count;
   } result_type;

endpackage

@@ rtl/tt_channels.sv @@
// -----------------------------------------------------------------------------
// tt_channels
// Request and response channels of the transposition table.
// -----------------------------------------------------------------------------
interface tt_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        command;
   logic [63:0]       key;
   logic [30:0]       move_in;
   logic signed [15:0] score_in;
   logic [1:0]        bound_kind;
   logic [6:0]        search_depth;
   logic signed [15:0] lower_window;
   logic signed [15:0] upper_window;
   logic [6:0]        ply_from_root;

   modport source (
      output valid, command, key, move_in, score_in, bound_kind, search_depth,
             lower_window, upper_window, ply_from_root,
      input  ready
   );
   modport sink (
      input  valid, command, key, move_in, score_in, bound_kind, search_depth,
             lower_window, upper_window, ply_from_root,
      output ready
   );
endinterface

interface tt_rsp_if;
   logic               valid;
   logic               ready;
   logic               key_match;
   logic               cutoff;
   logic [30:0]        move_out;
   logic signed [15:0] score_out;
   logic [31:0]        hit_count;
   logic [31:0]        new_write_count;
   logic [31:0]        overwrite_count;

   modport source (
      output valid, key_match, cutoff, move_out, score_out, hit_count,
             new_write_count, overwrite_count,
      input  ready
   );
   modport sink (
      input  valid, key_match, cutoff, move_out, score_out, hit_count,
             new_write_count, overwrite_count,
      output ready
   );
endinterface

@@ rtl/tt_front.sv @@
// -----------------------------------------------------------------------------
// tt_front
// Takes request words, derives the table index and the mate-adjusted store
// score, and holds the word until the queue takes it.
// -----------------------------------------------------------------------------
module tt_front (
   input  logic             clock,
   input  logic             reset,
   tt_req_if.sink           req_chan,
   input  logic [14:0]      mate_thr,
   output logic             out_valid,
   input  logic             out_ready,
   output tt_pkg::item_type out_item
);

   logic              hold_valid_ff, hold_valid_in;
   tt_pkg::item_type  item_ff, item_in;
   logic              take;
   logic signed [17:0] sc18, thr18, ply18, sum18;
   tt_pkg::score_type sat_score;

   assign req_chan.ready = !hold_valid_ff || out_ready;
   assign take           = req_chan.valid && req_chan.ready;
   assign out_valid      = hold_valid_ff;
   assign out_item       = item_ff;

   always_comb begin
      sc18  = 18'(req_chan.score_in);
      thr18 = 18'(mate_thr);
      ply18 = 18'(req_chan.ply_from_root);
      if (sc18 > thr18) begin
         sum18 = sc18 + ply18;
      end else if (sc18 < -thr18) begin
         sum18 = sc18 - ply18;
      end else begin
         sum18 = sc18;
      end
      if (sum18 > 18'sd32767) begin
         sat_score = 16'sh7FFF;
      end else if (sum18 < -18'sd32768) begin
         sat_score = 16'sh8000;
      end else begin
         sat_score = sum18[15:0];
      end

      item_in               = item_ff;
      hold_valid_in         = hold_valid_ff && !out_ready;
      if (take) begin
         item_in.command       = req_chan.command;
         item_in.key           = req_chan.key;
         item_in.idx           = req_chan.key[tt_pkg::INDEX_BITS-1:0];
         item_in.move_in       = req_chan.move_in;
         item_in.store_score   = sat_score;
         item_in.bound_kind    = req_chan.bound_kind;
         item_in.search_depth  = req_chan.search_depth;
         item_in.lower_window  = req_chan.lower_window;
         item_in.upper_window  = req_chan.upper_window;
         item_in.ply_from_root = req_chan.ply_from_root;
         hold_valid_in         = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

@@ rtl/tt_queue.sv @@
// -----------------------------------------------------------------------------
// tt_queue
// Short FIFO between the front and the back.
// -----------------------------------------------------------------------------
module tt_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  tt_pkg::item_type in_item,
   output logic             out_valid,
   input  logic             out_ready,
   output tt_pkg::item_type out_item
);

   tt_pkg::item_type                slot_ff [tt_pkg::QUEUE_DEPTH];
   logic [tt_pkg::QPTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [tt_pkg::QPTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [tt_pkg::QCNT_BITS-1:0]    count_ff, count_in;
   logic                            push, pop;

   assign in_ready  = count_ff != tt_pkg::QCNT_BITS'(tt_pkg::QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_item  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

@@ rtl/tt_back.sv @@
// -----------------------------------------------------------------------------
// tt_back
// Holds the entry memory and the counters; reads the indexed entry, then
// resolves the probe or writes the store; sweeps the memory on clear.
// -----------------------------------------------------------------------------
`include "transposition_table_macros.svh"

module tt_back (
   input  logic             clock,
   input  logic             reset,
   input  logic [14:0]      mate_thr,
   input  logic             q_valid,
   output logic             q_ready,
   input  tt_pkg::item_type q_item,
   tt_rsp_if.source         rsp_chan
);

   tt_pkg::entry_type       mem [tt_pkg::ENTRY_COUNT];
   tt_pkg::entry_type       rd_data_ff;
   tt_pkg::index_type       rd_addr, wr_addr;
   tt_pkg::entry_type       wr_data;
   logic                    wr_en;

   tt_pkg::back_state_type  state_ff, state_in;
   tt_pkg::index_type       sweep_ff, sweep_in;
   tt_pkg::item_type        item_ff, item_in;
   logic [31:0]             hits_ff, hits_in;
   logic [31:0]             new_ff, new_in;
   logic [31:0]             over_ff, over_in;
   tt_pkg::result_type      rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    q_pop, slot_free;

   logic                    match, depth_ok;
   logic signed [16:0]      sc17, thr17, ply17, adj17;
   tt_pkg::score_type       adj, alpha, beta;

   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign q_ready   = q_pop;

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.key_match       = rsp_ff.key_match;
   assign rsp_chan.cutoff          = rsp_ff.cutoff;
   assign rsp_chan.move_out        = rsp_ff.move_out;
   assign rsp_chan.score_out       = rsp_ff.score_out;
   assign rsp_chan.hit_count       = rsp_ff.hit_count;
   assign rsp_chan.new_write_count = rsp_ff.new_write_count;
   assign rsp_chan.overwrite_count = rsp_ff.overwrite_count;

   // probe resolution on the entry read back
   always_comb begin
      match    = rd_data_ff.valid && (rd_data_ff.key == item_ff.key);
      depth_ok = rd_data_ff.depth >= item_ff.search_depth;
      sc17     = 17'($signed(rd_data_ff.score));
      thr17    = 17'(mate_thr);
      ply17    = 17'(item_ff.ply_from_root);
      if (sc17 > thr17) begin
         adj17 = sc17 - ply17;
      end else if (sc17 < -thr17) begin
         adj17 = sc17 + ply17;
      end else begin
         adj17 = sc17;
      end
      adj   = adj17[15:0];
      alpha = item_ff.lower_window;
      beta  = item_ff.upper_window;
   end

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      item_in      = item_ff;
      hits_in      = hits_ff;
      new_in       = new_ff;
      over_in      = over_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      q_pop        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = sweep_ff;
      wr_data      = '0;
      rd_addr      = q_item.idx;

      case (state_ff)
         tt_pkg::BK_CLEAR: begin
            wr_en    = 1'b1;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == '1) begin
               state_in = tt_pkg::BK_IDLE;
            end
         end
         tt_pkg::BK_IDLE: begin
            if (q_valid && slot_free) begin
               q_pop   = 1'b1;
               item_in = q_item;
               case (q_item.command)
                  tt_pkg::CMD_PROBE, tt_pkg::CMD_STORE: begin
                     state_in = tt_pkg::BK_LOOK;
                  end
                  tt_pkg::CMD_CLEAR: begin
                     new_in       = '0;
                     rsp_in       = '0;
                     rsp_in.hit_count       = hits_ff;
                     rsp_in.overwrite_count = over_ff;
                     rsp_valid_in = 1'b1;
                     sweep_in     = '0;
                     state_in     = tt_pkg::BK_CLEAR;
                  end
                  default: begin
                     rsp_in       = '0;
                     rsp_in.hit_count       = hits_ff;
                     rsp_in.new_write_count = new_ff;
                     rsp_in.overwrite_count = over_ff;
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         tt_pkg::BK_LOOK: begin
            rsp_in = '0;
            if (item_ff.command == tt_pkg::CMD_STORE) begin
               if (rd_data_ff.valid) begin
                  over_in = over_ff + 32'd1;
               end else begin
                  new_in = new_ff + 32'd1;
               end
               wr_en         = 1'b1;
               wr_addr       = item_ff.idx;
               wr_data.valid = 1'b1;
               wr_data.key   = item_ff.key;
               wr_data.move  = item_ff.move_in;
               wr_data.score = item_ff.store_score;
               wr_data.depth = item_ff.search_depth;
               wr_data.bound = item_ff.bound_kind;
            end else if (match) begin
               rsp_in.key_match = 1'b1;
               rsp_in.move_out  = rd_data_ff.move;
               if (depth_ok) begin
                  hits_in          = hits_ff + 32'd1;
                  rsp_in.score_out = adj;
                  case (rd_data_ff.bound)
                     tt_pkg::BOUND_ALPHA: begin
                        if (adj <= alpha) begin
                           rsp_in.score_out = alpha;
                           rsp_in.cutoff    = 1'b1;
                        end
                     end
                     tt_pkg::BOUND_BETA: begin
                        if (adj >= beta) begin
                           rsp_in.score_out = beta;
                           rsp_in.cutoff    = 1'b1;
                        end
                     end
                     tt_pkg::BOUND_EXACT: begin
                        rsp_in.cutoff = 1'b1;
                     end
                     default: begin
                        rsp_in.cutoff = 1'b0;
                     end
                  endcase
               end
            end
            rsp_in.hit_count       = hits_in;
            rsp_in.new_write_count = new_in;
            rsp_in.overwrite_count = over_in;
            rsp_valid_in           = 1'b1;
            state_in               = tt_pkg::BK_IDLE;
         end
         default: begin
            state_in = tt_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tt_pkg::BK_CLEAR;
         sweep_ff     <= '0;
         hits_ff      <= '0;
         new_ff       <= '0;
         over_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         hits_ff      <= hits_in;
         new_ff       <= new_in;
         over_ff      <= over_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   // entry memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   `TT_ASSERT_IMPLIES(a_pop_idle, clock, reset, q_pop, state_ff == tt_pkg::BK_IDLE, "pop outside idle")
   `TT_ASSERT_IMPLIES(a_look_free, clock, reset, state_ff == tt_pkg::BK_LOOK, !rsp_valid_ff, "look with busy slot")
   `TT_ASSERT_NEXT(a_look_done, clock, reset, state_ff == tt_pkg::BK_LOOK, rsp_valid_ff && state_ff == tt_pkg::BK_IDLE, "look gave no word")
   `TT_ASSERT_IMPLIES(a_clear_write, clock, reset, state_ff == tt_pkg::BK_CLEAR, wr_en && !q_pop, "sweep stalled")

endmodule

@@ rtl/transposition_table.sv @@
// -----------------------------------------------------------------------------
// transposition_table
// Direct-mapped, always-replace search table with probe, store and clear.
// -----------------------------------------------------------------------------
// Request words arrive on req_chan (valid/ready); each gives exactly one
// response word on rsp_chan, in order. The table has 65536 entries indexed by
// the low key bits. A request passes a front register and a two-word queue;
// the back reads the entry in its idle state and resolves or writes it in the
// next, its look state, and the response word is held in the response
// register. The back takes no new request until the last has left its look
// state and the response register is free. A clear is answered as the back
// leaves idle, then sweeps the memory one entry a cycle, all 65536 entries,
// during which no request leaves the queue. Reset performs the same sweep and
// zeroes the counters; the mate threshold resets to 29000. The user must write
// it through csr_wr_en/csr_wr_data only while idle; the block does not enforce
// it. If the receiver stalls, the response register holds its word; requests
// still fill the front register and the queue until they are full.
// -----------------------------------------------------------------------------
module transposition_table (
   input  logic        clock,
   input  logic        reset,
   tt_req_if.sink      req_chan,
   tt_rsp_if.source    rsp_chan,
   input  logic        csr_wr_en,
   input  logic [14:0] csr_wr_data
);

   logic [14:0]       mate_thr_ff, mate_thr_in;
   logic              f_valid, f_ready;
   tt_pkg::item_type  f_item;
   logic              q_valid, q_ready;
   tt_pkg::item_type  q_item;

   assign mate_thr_in = csr_wr_en ? csr_wr_data : mate_thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mate_thr_ff <= tt_pkg::MATE_RESET;
      end else begin
         mate_thr_ff <= mate_thr_in;
      end
   end

   tt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .mate_thr  (mate_thr_ff),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_item  (f_item)
   );

   tt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_item   (f_item),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   tt_back u_back (
      .clock    (clock),
      .reset    (reset),
      .mate_thr (mate_thr_ff),
      .q_valid  (q_valid),
      .q_ready  (q_ready),
      .q_item   (q_item),
      .rsp_chan (rsp_chan)
   );

endmodule
